// ----- rtl/tfv_pkg.sv -----
// ----------------------------------------------------------------------------
// tfv_pkg
// shared constants and types of the ipv4/tcp frame validator
// ----------------------------------------------------------------------------
package tfv_pkg;

    localparam int MAX_FRAME_BYTES   = 1518;
    localparam int MAX_PAYLOAD_BYTES = 512;

    localparam int INDEX_W     = 11;
    localparam int INDEX_MAX   = 2047;
    localparam int COUNT_W     = 12;
    localparam int ETH_BYTES   = 14;
    localparam int IP_MIN_HDR  = 20;
    localparam int HDR_MIN     = 20;
    localparam int HDR_MAX     = 60;
    localparam int TCP_MIN_HDR = 20;
    localparam int MIN_FRAME   = ETH_BYTES + IP_MIN_HDR + TCP_MIN_HDR;
    localparam int SEG_MAX     = TCP_MIN_HDR + MAX_PAYLOAD_BYTES;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] SUM_ALL_ONES   = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // everything the back end needs from one frame
    typedef struct packed {
        logic [COUNT_W-1:0] frame_len;
        logic [15:0]        ether_type;
        logic [7:0]         version_ihl;
        logic [7:0]         protocol;
        logic [15:0]        total_length;
        logic [31:0]        src_addr;
        logic [31:0]        dst_addr;
        logic [63:0]        ports_seq;
        logic [31:0]        ack;
        logic [31:0]        offset_flags_window;
        logic [15:0]        ip_sum;
        logic [15:0]        segment_sum;
        logic [7:0]         high_byte_hold;
    } frame_summary_t;

    // header checks done, checksum partly added up
    typedef struct packed {
        logic        hdr_ok;
        logic [17:0] sum_a;
        logic [17:0] sum_b;
        logic [15:0] seg_len;
        logic [5:0]  ip_header_bytes;
        logic [5:0]  tcp_header_bytes;
        logic [15:0] ip_total_length;
        logic [31:0] source_address;
        logic [63:0] ports_seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] window;
    } check_stage_t;

    // packed so that frame_ok sits in the lowest bit
    typedef struct packed {
        logic [15:0] peer_window;
        logic [7:0]  tcp_flag_bits;
        logic [31:0] ack_number;
        logic [31:0] sequence_number;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] source_address;
        logic [15:0] ip_total_length;
        logic [5:0]  tcp_header_bytes;
        logic [5:0]  ip_header_bytes;
        logic        frame_ok;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // ones' complement add with end-around carry
    function automatic logic [15:0] csum_add(input logic [15:0] sum, input logic [15:0] word);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, sum} + {1'b0, word};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

// ----- rtl/tfv_front.sv -----
// ----------------------------------------------------------------------------
// tfv_front
// byte parser: captures header fields and folds both checksums per beat
// ----------------------------------------------------------------------------
module tfv_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             frame_byte,
    input  logic                   last_byte,
    output logic                   byte_ready,
    output logic                   summary_valid,
    output tfv_pkg::frame_summary_t summary,
    input  logic                   queue_ready
);

    logic [tfv_pkg::INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0] ip_sum_reg, ip_sum_next;
    logic [15:0] segment_sum_reg, segment_sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic [63:0] ports_seq_reg, ports_seq_next;
    logic [31:0] ack_reg, ack_next;
    logic [31:0] ofw_reg, ofw_next;

    logic                        accept;
    logic [tfv_pkg::INDEX_W-1:0] pos;
    logic [tfv_pkg::INDEX_W-1:0] ip_off;
    logic [tfv_pkg::INDEX_W-1:0] tcp_off;
    logic [5:0]                  ihl_bytes;
    logic [tfv_pkg::INDEX_W-1:0] seg_start;
    logic [16:0]                 seg_end;
    logic                        in_ip_fields;
    logic                        in_ip_hdr;
    logic                        in_segment;
    logic                        in_tcp_fields;
    logic [15:0]                 word;

    assign accept     = byte_valid && queue_ready;
    assign byte_ready = queue_ready;
    assign pos        = byte_index_reg;

    always_comb
    begin
        ether_type_next   = ether_type_reg;
        version_ihl_next  = version_ihl_reg;
        total_length_next = total_length_reg;
        protocol_next     = protocol_reg;
        src_addr_next     = src_addr_reg;
        dst_addr_next     = dst_addr_reg;
        ip_sum_next       = ip_sum_reg;
        segment_sum_next  = segment_sum_reg;
        hold_next         = hold_reg;
        ports_seq_next    = ports_seq_reg;
        ack_next          = ack_reg;
        ofw_next          = ofw_reg;

        if (pos == tfv_pkg::INDEX_W'(12))
            ether_type_next = {frame_byte, ether_type_reg[7:0]};
        if (pos == tfv_pkg::INDEX_W'(13))
            ether_type_next = {ether_type_reg[15:8], frame_byte};

        ip_off       = pos - tfv_pkg::INDEX_W'(tfv_pkg::ETH_BYTES);
        in_ip_fields = (pos >= tfv_pkg::INDEX_W'(tfv_pkg::ETH_BYTES))
                    && (pos < tfv_pkg::INDEX_W'(tfv_pkg::ETH_BYTES + tfv_pkg::IP_MIN_HDR));
        if (in_ip_fields)
        begin
            if (ip_off == tfv_pkg::INDEX_W'(0))
                version_ihl_next = frame_byte;
            else if (ip_off == tfv_pkg::INDEX_W'(2))
                total_length_next = {frame_byte, total_length_reg[7:0]};
            else if (ip_off == tfv_pkg::INDEX_W'(3))
                total_length_next = {total_length_reg[15:8], frame_byte};
            else if (ip_off == tfv_pkg::INDEX_W'(9))
                protocol_next = frame_byte;
            else if (ip_off >= tfv_pkg::INDEX_W'(12) && ip_off < tfv_pkg::INDEX_W'(16))
                src_addr_next = {src_addr_reg[23:0], frame_byte};
            else if (ip_off >= tfv_pkg::INDEX_W'(16))
                dst_addr_next = {dst_addr_reg[23:0], frame_byte};
        end

        // boundaries follow the header fields as they are written this beat
        ihl_bytes = {version_ihl_next[3:0], 2'b00};
        seg_start = tfv_pkg::INDEX_W'(tfv_pkg::ETH_BYTES) + {5'd0, ihl_bytes};
        seg_end   = 17'(tfv_pkg::ETH_BYTES) + {1'b0, total_length_next};

        in_ip_hdr  = (pos >= tfv_pkg::INDEX_W'(tfv_pkg::ETH_BYTES)) && (pos < seg_start);
        in_segment = !in_ip_hdr && (pos >= seg_start) && ({6'd0, pos} < seg_end);
        word       = {hold_reg, frame_byte};

        if (in_ip_hdr || in_segment)
        begin
            if (!pos[0])
                hold_next = frame_byte;
            else if (in_ip_hdr)
                ip_sum_next = tfv_pkg::csum_add(ip_sum_reg, word);
            else
                segment_sum_next = tfv_pkg::csum_add(segment_sum_reg, word);
        end

        tcp_off       = pos - seg_start;
        in_tcp_fields = (pos >= seg_start)
                     && (pos < seg_start + tfv_pkg::INDEX_W'(tfv_pkg::TCP_MIN_HDR));
        if (in_tcp_fields)
        begin
            if (tcp_off < tfv_pkg::INDEX_W'(8))
                ports_seq_next = {ports_seq_reg[55:0], frame_byte};
            else if (tcp_off < tfv_pkg::INDEX_W'(12))
                ack_next = {ack_reg[23:0], frame_byte};
            else if (tcp_off < tfv_pkg::INDEX_W'(16))
                ofw_next = {ofw_reg[23:0], frame_byte};
        end

        if (byte_index_reg < tfv_pkg::INDEX_W'(tfv_pkg::INDEX_MAX))
            byte_index_next = byte_index_reg + tfv_pkg::INDEX_W'(1);
        else
            byte_index_next = byte_index_reg;
    end

    always_comb
    begin
        summary.frame_len           = {1'b0, pos} + tfv_pkg::COUNT_W'(1);
        summary.ether_type          = ether_type_next;
        summary.version_ihl         = version_ihl_next;
        summary.protocol            = protocol_next;
        summary.total_length        = total_length_next;
        summary.src_addr            = src_addr_next;
        summary.dst_addr            = dst_addr_next;
        summary.ports_seq           = ports_seq_next;
        summary.ack                 = ack_next;
        summary.offset_flags_window = ofw_next;
        summary.ip_sum              = ip_sum_next;
        summary.segment_sum         = segment_sum_next;
        summary.high_byte_hold      = hold_next;
    end

    assign summary_valid = accept && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            ip_sum_reg       <= '0;
            segment_sum_reg  <= '0;
            hold_reg         <= '0;
            ether_type_reg   <= '0;
            version_ihl_reg  <= '0;
            protocol_reg     <= '0;
            total_length_reg <= '0;
            src_addr_reg     <= '0;
            dst_addr_reg     <= '0;
            ports_seq_reg    <= '0;
            ack_reg          <= '0;
            ofw_reg          <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // frame done, start the next one from clean state
                byte_index_reg   <= '0;
                ip_sum_reg       <= '0;
                segment_sum_reg  <= '0;
                hold_reg         <= '0;
                ether_type_reg   <= '0;
                version_ihl_reg  <= '0;
                protocol_reg     <= '0;
                total_length_reg <= '0;
                src_addr_reg     <= '0;
                dst_addr_reg     <= '0;
                ports_seq_reg    <= '0;
                ack_reg          <= '0;
                ofw_reg          <= '0;
            end
            else
            begin
                byte_index_reg   <= byte_index_next;
                ip_sum_reg       <= ip_sum_next;
                segment_sum_reg  <= segment_sum_next;
                hold_reg         <= hold_next;
                ether_type_reg   <= ether_type_next;
                version_ihl_reg  <= version_ihl_next;
                protocol_reg     <= protocol_next;
                total_length_reg <= total_length_next;
                src_addr_reg     <= src_addr_next;
                dst_addr_reg     <= dst_addr_next;
                ports_seq_reg    <= ports_seq_next;
                ack_reg          <= ack_next;
                ofw_reg          <= ofw_next;
            end
        end
    end

`ifndef SYNTH
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> byte_index_reg == '0 && ip_sum_reg == '0)
        else $error("front did not restart after last beat");

    a_index_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_byte && byte_index_reg == tfv_pkg::INDEX_W'(tfv_pkg::INDEX_MAX)
        |=> byte_index_reg == tfv_pkg::INDEX_W'(tfv_pkg::INDEX_MAX))
        else $error("byte index wrapped");
`endif

endmodule

// ----- rtl/tfv_queue.sv -----
// ----------------------------------------------------------------------------
// tfv_queue
// short fifo of frame summaries between parser and checker
// ----------------------------------------------------------------------------
module tfv_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tfv_pkg::frame_summary_t push_data,
    output logic                    push_ready,
    output logic                    pop_valid,
    output tfv_pkg::frame_summary_t pop_data,
    input  logic                    pop
);

    tfv_pkg::frame_summary_t entry_reg [tfv_pkg::QUEUE_DEPTH];

    logic [tfv_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tfv_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tfv_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = count_reg != tfv_pkg::QUEUE_CNT_W'(tfv_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + tfv_pkg::QUEUE_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + tfv_pkg::QUEUE_PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + tfv_pkg::QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - tfv_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("summary pushed into a full queue");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tfv_pkg::QUEUE_CNT_W'(tfv_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- rtl/tfv_back.sv -----
// ----------------------------------------------------------------------------
// tfv_back
// checker: header tests, pseudo header sum and result register
// ----------------------------------------------------------------------------
module tfv_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  tfv_pkg::frame_summary_t in_data,
    output logic                    in_ready,
    output logic                    res_valid,
    output tfv_pkg::result_t        res,
    input  logic                    res_ready
);

    tfv_pkg::check_stage_t chk_reg, chk_next;
    logic                  chk_valid_reg;
    tfv_pkg::result_t      res_reg, res_next;
    logic                  res_valid_reg;

    logic        out_free;
    logic        chk_load;
    logic [5:0]  ihl;
    logic [5:0]  thl;
    logic [16:0] n17;
    logic [16:0] len17;
    logic [16:0] ihl17;
    logic [15:0] pad_word;
    logic [19:0] total;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic        sum_ok;

    assign out_free = !res_valid_reg || res_ready;
    assign in_ready = !chk_valid_reg || out_free;
    assign chk_load = in_valid && in_ready;

    // stage one: all header tests, first half of the pseudo header sum
    always_comb
    begin
        ihl   = {in_data.version_ihl[3:0], 2'b00};
        thl   = {in_data.offset_flags_window[31:28], 2'b00};
        n17   = {5'd0, in_data.frame_len};
        len17 = {1'b0, in_data.total_length};
        ihl17 = {11'd0, ihl};

        chk_next.hdr_ok =
               (n17 >= 17'(tfv_pkg::MIN_FRAME))
            && (n17 <= 17'(tfv_pkg::MAX_FRAME_BYTES))
            && (in_data.ether_type == tfv_pkg::ETHERTYPE_IPV4)
            && (in_data.version_ihl[7:4] == tfv_pkg::IP_VERSION_4)
            && (in_data.protocol == tfv_pkg::PROTO_TCP)
            && (ihl >= 6'(tfv_pkg::HDR_MIN)) && (ihl <= 6'(tfv_pkg::HDR_MAX))
            && (n17 >= ihl17 + 17'(tfv_pkg::ETH_BYTES + tfv_pkg::TCP_MIN_HDR))
            && (in_data.ip_sum == tfv_pkg::SUM_ALL_ONES)
            && (len17 >= ihl17 + 17'(tfv_pkg::TCP_MIN_HDR))
            && (len17 + 17'(tfv_pkg::ETH_BYTES) <= n17)
            && (thl >= 6'(tfv_pkg::HDR_MIN)) && (thl <= 6'(tfv_pkg::HDR_MAX))
            && (len17 >= ihl17 + {11'd0, thl})
            && (len17 <= ihl17 + 17'(tfv_pkg::SEG_MAX));

        // segment length is odd exactly when the total length is, ihl being a multiple of four
        pad_word = in_data.total_length[0] ? {in_data.high_byte_hold, 8'd0} : 16'd0;

        chk_next.sum_a = {2'd0, in_data.segment_sum} + {2'd0, pad_word}
                       + {2'd0, in_data.src_addr[31:16]} + {2'd0, in_data.src_addr[15:0]};
        chk_next.sum_b = {2'd0, in_data.dst_addr[31:16]} + {2'd0, in_data.dst_addr[15:0]}
                       + {10'd0, tfv_pkg::PROTO_TCP};
        chk_next.seg_len          = in_data.total_length - {10'd0, ihl};
        chk_next.ip_header_bytes  = ihl;
        chk_next.tcp_header_bytes = thl;
        chk_next.ip_total_length  = in_data.total_length;
        chk_next.source_address   = in_data.src_addr;
        chk_next.ports_seq        = in_data.ports_seq;
        chk_next.ack              = in_data.ack;
        chk_next.flags            = in_data.offset_flags_window[23:16];
        chk_next.window           = in_data.offset_flags_window[15:0];
    end

    // stage two: finish the sum, fold twice and build the result
    always_comb
    begin
        total  = {2'd0, chk_reg.sum_a} + {2'd0, chk_reg.sum_b} + {4'd0, chk_reg.seg_len};
        fold1  = {1'b0, total[15:0]} + {13'd0, total[19:16]};
        fold2  = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        sum_ok = fold2[15:0] == tfv_pkg::SUM_ALL_ONES;

        res_next = '0;
        if (chk_reg.hdr_ok && sum_ok)
        begin
            res_next.frame_ok         = 1'b1;
            res_next.ip_header_bytes  = chk_reg.ip_header_bytes;
            res_next.tcp_header_bytes = chk_reg.tcp_header_bytes;
            res_next.ip_total_length  = chk_reg.ip_total_length;
            res_next.source_address   = chk_reg.source_address;
            res_next.source_port      = chk_reg.ports_seq[63:48];
            res_next.dest_port        = chk_reg.ports_seq[47:32];
            res_next.sequence_number  = chk_reg.ports_seq[31:0];
            res_next.ack_number       = chk_reg.ack;
            res_next.tcp_flag_bits    = chk_reg.flags;
            res_next.peer_window      = chk_reg.window;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                chk_valid_reg <= in_valid;
            if (out_free)
                res_valid_reg <= chk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_load)
            chk_reg <= chk_next;
        if (out_free && chk_valid_reg)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTH
    a_reject_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.frame_ok
        |-> res_reg.source_address == '0 && res_reg.ip_total_length == '0
            && res_reg.sequence_number == '0)
        else $error("rejected frame carries header fields");
`endif

endmodule

// ----- rtl/tcp_ipv4_frame_validator_core.sv -----
// ----------------------------------------------------------------------------
// tcp_ipv4_frame_validator_core
// ethernet/ipv4/tcp header and checksum check on a byte stream
// ----------------------------------------------------------------------------
// usage
//   input: one frame byte per beat on s_axis, tlast on the final byte.
//   output: one beat on m_axis per frame, carrying frame_ok and the parsed
//   header fields; on a rejected frame every field but frame_ok is zero.
//   bytes past the ipv4 total length are counted for the frame length only.
// throughput
//   one byte per cycle while the summary queue has room, with no gap between
//   frames. the checker takes one frame per cycle while m_axis is not stalled.
// result path
//   the edge that takes the last byte writes the summary into the queue;
//   it then passes the header/sum stage register and the result register.
// stalls
//   a two-entry summary queue sits between the byte parser and the checker;
//   s_axis_tready drops only when that queue is full, i.e. when m_axis holds
//   tready low with the check and result stages full and two more frames queued.
// reset
//   rst_n clears the parser position, sums, queue and output valid; the
//   first byte after reset is taken as the first byte of a frame.
// ----------------------------------------------------------------------------
module tcp_ipv4_frame_validator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // frame_byte
    input  logic                        s_axis_tlast,   // last_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // frame_ok, ip_header_bytes, tcp_header_bytes, ip_total_length,
    // source_address, source_port, dest_port, sequence_number, ack_number,
    // tcp_flag_bits, peer_window, zero fill
    output logic [tfv_pkg::TDATA_W-1:0] m_axis_tdata
);

    tfv_pkg::frame_summary_t front_summary;
    tfv_pkg::frame_summary_t queue_head;
    tfv_pkg::result_t        result;
    logic                    front_push;
    logic                    queue_ready;
    logic                    queue_valid;
    logic                    back_ready;

    tfv_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (s_axis_tvalid),
        .frame_byte    (s_axis_tdata),
        .last_byte     (s_axis_tlast),
        .byte_ready    (s_axis_tready),
        .summary_valid (front_push),
        .summary       (front_summary),
        .queue_ready   (queue_ready)
    );

    tfv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_data  (front_summary),
        .push_ready (queue_ready),
        .pop_valid  (queue_valid),
        .pop_data   (queue_head),
        .pop        (back_ready)
    );

    tfv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_data   (queue_head),
        .in_ready  (back_ready),
        .res_valid (m_axis_tvalid),
        .res       (result),
        .res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(tfv_pkg::TDATA_W - tfv_pkg::RESULT_W){1'b0}}, result};

endmodule

// ----- dv/tb_tcp_ipv4_frame_validator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_ipv4_frame_validator_core
// self-checking bench for the ipv4/tcp frame validator
// ----------------------------------------------------------------------------
// frames are built byte by byte with correct or deliberately broken headers
// and checksums, streamed in one byte per beat, and every result beat is
// compared field by field against a byte-level model of the validator that
// runs on the accepted input beats.
// ----------------------------------------------------------------------------
module tb_tcp_ipv4_frame_validator_core;

    localparam int CYCLE_LIMIT = 400000;

    // byte positions within the frame
    localparam int POS_ETHERTYPE = 12;
    localparam int POS_VER_IHL   = 14;
    localparam int POS_TOTAL_LEN = 16;
    localparam int POS_PROTOCOL  = 23;
    localparam int POS_IP_CSUM   = 24;
    localparam int POS_SRC_ADDR  = 26;
    localparam int POS_DST_ADDR  = 30;
    // byte offsets within the tcp header
    localparam int TCP_OFS_DOFF  = 12;
    localparam int TCP_OFS_CSUM  = 16;

    localparam logic [7:0] ETHERTYPE_IPV6_HI = 8'h86;
    localparam logic [7:0] PROTO_UDP         = 8'd17;
    localparam logic [3:0] IP_VERSION_6      = 4'd6;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_e;

    logic                         clk;
    logic                         rst_n         = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata  = 8'h00;
    logic                         s_axis_tlast  = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [tfv_pkg::TDATA_W-1:0]  m_axis_tdata;

    tcp_ipv4_frame_validator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // frame model state
    int          byte_pos   = 0;
    logic [15:0] ip_acc     = '0;
    logic [15:0] seg_acc    = '0;
    logic [7:0]  held_byte  = '0;
    logic [15:0] eth_type   = '0;
    logic [7:0]  ver_ihl    = '0;
    logic [7:0]  proto      = '0;
    logic [15:0] tot_len    = '0;
    logic [31:0] src_ip     = '0;
    logic [31:0] dst_ip     = '0;
    logic [63:0] ports_seq  = '0;
    logic [31:0] ack_word   = '0;
    logic [31:0] offs_flags_win = '0;

    tfv_pkg::result_t expected_verdicts[$];
    logic [7:0]       frame_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_id    = 0;
    int hold_req_len   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    int cycle_count     = 0;
    int mismatches      = 0;
    int bytes_sent      = 0;
    int frames_sent     = 0;
    int results_seen    = 0;
    int accepted_frames = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // byte-level model: captures headers, keeps both sums, judges on the last byte
    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        int          pos, ofs, t, ihl, seg_start, seg_end, n, ip_len, thl, seg_len;
        logic [15:0] tsum;
        bit          ok;
        tfv_pkg::result_t r;
        pos = byte_pos;
        if (pos == POS_ETHERTYPE)
            eth_type[15:8] = b;
        if (pos == POS_ETHERTYPE + 1)
            eth_type[7:0] = b;
        if (pos >= tfv_pkg::ETH_BYTES && pos < tfv_pkg::ETH_BYTES + 20)
        begin
            ofs = pos - tfv_pkg::ETH_BYTES;
            if (ofs == 0)
                ver_ihl = b;
            else if (ofs == 2)
                tot_len[15:8] = b;
            else if (ofs == 3)
                tot_len[7:0] = b;
            else if (ofs == 9)
                proto = b;
            else if (ofs >= 12 && ofs < 16)
                src_ip = {src_ip[23:0], b};
            else if (ofs >= 16)
                dst_ip = {dst_ip[23:0], b};
        end

        ihl       = ver_ihl[3:0] * 4;
        seg_start = tfv_pkg::ETH_BYTES + ihl;
        seg_end   = tfv_pkg::ETH_BYTES + tot_len;

        if (pos >= tfv_pkg::ETH_BYTES && pos < seg_start)
        begin
            if (pos % 2 == 0)
                held_byte = b;
            else
                ip_acc = ones_add(ip_acc, {held_byte, b});
        end
        else if (pos >= seg_start && pos < seg_end)
        begin
            if (pos % 2 == 0)
                held_byte = b;
            else
                seg_acc = ones_add(seg_acc, {held_byte, b});
        end

        if (pos >= seg_start && pos < seg_start + 20)
        begin
            t = pos - seg_start;
            if (t < 8)
                ports_seq = {ports_seq[55:0], b};
            else if (t < 12)
                ack_word = {ack_word[23:0], b};
            else if (t < 16)
                offs_flags_win = {offs_flags_win[23:0], b};
        end

        if (byte_pos < tfv_pkg::INDEX_MAX)
            byte_pos++;

        if (last)
        begin
            n       = pos + 1;
            ip_len  = tot_len;
            thl     = offs_flags_win[31:28] * 4;
            seg_len = ip_len - ihl;
            ok = n >= tfv_pkg::MIN_FRAME && n <= tfv_pkg::MAX_FRAME_BYTES
                && eth_type == tfv_pkg::ETHERTYPE_IPV4
                && ver_ihl[7:4] == tfv_pkg::IP_VERSION_4
                && proto == tfv_pkg::PROTO_TCP
                && ihl >= tfv_pkg::HDR_MIN && ihl <= tfv_pkg::HDR_MAX
                && n >= tfv_pkg::ETH_BYTES + ihl + tfv_pkg::TCP_MIN_HDR
                && ip_acc == tfv_pkg::SUM_ALL_ONES
                && ip_len >= ihl + tfv_pkg::TCP_MIN_HDR
                && ip_len <= n - tfv_pkg::ETH_BYTES
                && thl >= tfv_pkg::HDR_MIN && thl <= tfv_pkg::HDR_MAX
                && ip_len >= ihl + thl
                && seg_len <= tfv_pkg::SEG_MAX;
            if (ok)
            begin
                tsum = seg_acc;
                // odd segment: last byte is padded with a zero low byte
                if (seg_len % 2 == 1)
                    tsum = ones_add(tsum, {held_byte, 8'h00});
                tsum = ones_add(tsum, src_ip[31:16]);
                tsum = ones_add(tsum, src_ip[15:0]);
                tsum = ones_add(tsum, dst_ip[31:16]);
                tsum = ones_add(tsum, dst_ip[15:0]);
                tsum = ones_add(tsum, {8'h00, tfv_pkg::PROTO_TCP});
                tsum = ones_add(tsum, seg_len[15:0]);
                ok = tsum == tfv_pkg::SUM_ALL_ONES;
            end
            r = '0;
            if (ok)
            begin
                r.frame_ok         = 1'b1;
                r.ip_header_bytes  = ihl[5:0];
                r.tcp_header_bytes = thl[5:0];
                r.ip_total_length  = tot_len;
                r.source_address   = src_ip;
                r.source_port      = ports_seq[63:48];
                r.dest_port        = ports_seq[47:32];
                r.sequence_number  = ports_seq[31:0];
                r.ack_number       = ack_word;
                r.tcp_flag_bits    = offs_flags_win[23:16];
                r.peer_window      = offs_flags_win[15:0];
            end
            expected_verdicts.push_back(r);

            byte_pos = 0;
            ip_acc = '0; seg_acc = '0; held_byte = '0;
            eth_type = '0; ver_ihl = '0; proto = '0; tot_len = '0;
            src_ip = '0; dst_ip = '0; ports_seq = '0; ack_word = '0;
            offs_flags_win = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s at result %0d: expected %0h, got %0h",
                         name, results_seen, want, got);
        end
    endtask

    task automatic compare_verdict(input tfv_pkg::result_t got);
        tfv_pkg::result_t want;
        if (expected_verdicts.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat with nothing expected: frame_ok=%0b", got.frame_ok);
            return;
        end
        want = expected_verdicts.pop_front();
        results_seen++;
        if (want.frame_ok)
            accepted_frames++;
        check_field("frame_ok",         want.frame_ok,         got.frame_ok);
        check_field("ip_header_bytes",  want.ip_header_bytes,  got.ip_header_bytes);
        check_field("tcp_header_bytes", want.tcp_header_bytes, got.tcp_header_bytes);
        check_field("ip_total_length",  want.ip_total_length,  got.ip_total_length);
        check_field("source_address",   want.source_address,   got.source_address);
        check_field("source_port",      want.source_port,      got.source_port);
        check_field("dest_port",        want.dest_port,        got.dest_port);
        check_field("sequence_number",  want.sequence_number,  got.sequence_number);
        check_field("ack_number",       want.ack_number,       got.ack_number);
        check_field("tcp_flag_bits",    want.tcp_flag_bits,    got.tcp_flag_bits);
        check_field("peer_window",      want.peer_window,      got.peer_window);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            track_frame_byte(s_axis_tdata, s_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            compare_verdict(tfv_pkg::result_t'(m_axis_tdata[tfv_pkg::RESULT_W-1:0]));
    end

    // output side: random stalls, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_req_id != hold_seen)
        begin
            hold_seen = hold_req_id;
            hold_left = hold_req_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] fill_byte(input fill_mode_e mode);
        case (mode)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return $urandom_range(255);
        endcase
    endfunction

    task automatic fix_ip_csum();
        int          hlen, i;
        logic [15:0] s;
        hlen = frame_buf[POS_VER_IHL][3:0] * 4;
        frame_buf[POS_IP_CSUM]     = 8'h00;
        frame_buf[POS_IP_CSUM + 1] = 8'h00;
        s = '0;
        for (i = 0; i < hlen; i += 2)
            s = ones_add(s, {frame_buf[POS_VER_IHL + i], frame_buf[POS_VER_IHL + i + 1]});
        s = ~s;
        frame_buf[POS_IP_CSUM]     = s[15:8];
        frame_buf[POS_IP_CSUM + 1] = s[7:0];
    endtask

    // tcp checksum over pseudo header and segment as the header fields now say
    task automatic fix_tcp_csum();
        int          hlen, tl, seg, st, i;
        logic [7:0]  lo;
        logic [15:0] s;
        hlen = frame_buf[POS_VER_IHL][3:0] * 4;
        tl   = {frame_buf[POS_TOTAL_LEN], frame_buf[POS_TOTAL_LEN + 1]};
        seg  = tl - hlen;
        st   = tfv_pkg::ETH_BYTES + hlen;
        frame_buf[st + TCP_OFS_CSUM]     = 8'h00;
        frame_buf[st + TCP_OFS_CSUM + 1] = 8'h00;
        s = '0;
        for (i = 0; i < seg; i += 2)
        begin
            lo = (i + 1 < seg) ? frame_buf[st + i + 1] : 8'h00;
            s = ones_add(s, {frame_buf[st + i], lo});
        end
        for (i = 0; i < 8; i += 2)
            s = ones_add(s, {frame_buf[POS_SRC_ADDR + i], frame_buf[POS_SRC_ADDR + i + 1]});
        s = ones_add(s, {8'h00, tfv_pkg::PROTO_TCP});
        s = ones_add(s, seg[15:0]);
        s = ~s;
        frame_buf[st + TCP_OFS_CSUM]     = s[15:8];
        frame_buf[st + TCP_OFS_CSUM + 1] = s[7:0];
    endtask

    task automatic build_frame(input int ihl_w, input int doff_w, input int payload,
                               input int trailing, input fill_mode_e fill);
        int         hlen, tlen, tl, i;
        logic [7:0] v;
        hlen = ihl_w * 4;
        tlen = doff_w * 4;
        tl   = hlen + tlen + payload;
        frame_buf.delete();
        repeat (12) frame_buf.push_back($urandom_range(255));
        frame_buf.push_back(tfv_pkg::ETHERTYPE_IPV4[15:8]);
        frame_buf.push_back(tfv_pkg::ETHERTYPE_IPV4[7:0]);
        for (i = 0; i < hlen; i++)
        begin
            case (i)
                0:       frame_buf.push_back({tfv_pkg::IP_VERSION_4, ihl_w[3:0]});
                2:       frame_buf.push_back(tl[15:8]);
                3:       frame_buf.push_back(tl[7:0]);
                9:       frame_buf.push_back(tfv_pkg::PROTO_TCP);
                10, 11:  frame_buf.push_back(8'h00);
                12, 13, 14, 15, 16, 17, 18, 19:
                         frame_buf.push_back(fill_byte(fill));
                default: frame_buf.push_back($urandom_range(255));
            endcase
        end
        for (i = 0; i < tlen; i++)
        begin
            v = fill_byte(fill);
            if (i < TCP_OFS_DOFF || (i > TCP_OFS_DOFF && i < TCP_OFS_CSUM))
                frame_buf.push_back(v);
            else if (i == TCP_OFS_DOFF)
                frame_buf.push_back({doff_w[3:0], v[3:0]});
            else
                frame_buf.push_back($urandom_range(255));
        end
        repeat (payload + trailing) frame_buf.push_back($urandom_range(255));
        fix_ip_csum();
        fix_tcp_csum();
    endtask

    task automatic build_random_frame();
        int         ihl_w, doff_w, payload, trailing, r;
        fill_mode_e fill;
        ihl_w  = $urandom_range(1) ? 5 : $urandom_range(5, 15);
        doff_w = $urandom_range(1) ? 5 : $urandom_range(5, 15);
        r = $urandom_range(99);
        if (r < 85)
            payload = $urandom_range(40);
        else if (r < 97)
            payload = $urandom_range(41, 200);
        else
            payload = $urandom_range(500, 530);
        trailing = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 10);
        r = $urandom_range(19);
        fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM;
        build_frame(ihl_w, doff_w, payload, trailing, fill);
    endtask

    task automatic test_good_frames();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        build_frame(5, 5, 0, 0, FILL_RANDOM);       // shortest legal frame
        send_frame();
        build_frame(15, 15, 7, 0, FILL_ONES);       // widest headers, odd segment
        send_frame();
        build_frame(5, 5, 1, 0, FILL_ZERO);
        send_frame();
        build_frame(5, 6, 10, 21, FILL_RANDOM);     // padding past total length
        send_frame();
        build_frame(5, 5, tfv_pkg::MAX_PAYLOAD_BYTES, 0, FILL_RANDOM);
        send_frame();
        wait_drained();
    endtask

    task automatic test_length_limits();
        int tl;
        build_frame(5, 5, tfv_pkg::MAX_PAYLOAD_BYTES + 1, 0, FILL_RANDOM);
        send_frame();
        build_frame(5, 5, 0, tfv_pkg::MAX_FRAME_BYTES - tfv_pkg::MIN_FRAME, FILL_RANDOM);
        send_frame();
        build_frame(5, 5, 0, tfv_pkg::MAX_FRAME_BYTES + 1 - tfv_pkg::MIN_FRAME, FILL_RANDOM);
        send_frame();
        // beyond the position counter range
        build_frame(5, 5, 0, tfv_pkg::INDEX_MAX + 3 - tfv_pkg::MIN_FRAME, FILL_RANDOM);
        send_frame();
        build_frame(5, 5, 0, 0, FILL_RANDOM);       // runt, one byte short
        void'(frame_buf.pop_back());
        send_frame();
        frame_buf.delete();
        frame_buf.push_back($urandom_range(255));
        send_frame();
        // total length claims one byte more than the frame holds
        build_frame(5, 5, 4, 0, FILL_RANDOM);
        tl = frame_buf.size() - tfv_pkg::ETH_BYTES + 1;
        frame_buf[POS_TOTAL_LEN]     = tl[15:8];
        frame_buf[POS_TOTAL_LEN + 1] = tl[7:0];
        fix_ip_csum();
        send_frame();
        // total length too short for the tcp header it carries
        build_frame(5, 8, 0, 0, FILL_RANDOM);
        tl = 40;
        frame_buf[POS_TOTAL_LEN]     = tl[15:8];
        frame_buf[POS_TOTAL_LEN + 1] = tl[7:0];
        fix_ip_csum();
        send_frame();
        wait_drained();
    endtask

    task automatic test_header_faults();
        int st;
        build_frame(5, 5, 6, 0, FILL_RANDOM);
        frame_buf[POS_ETHERTYPE] = ETHERTYPE_IPV6_HI;
        send_frame();
        build_frame(5, 5, 6, 0, FILL_RANDOM);
        frame_buf[POS_VER_IHL] = {IP_VERSION_6, 4'd5};
        fix_ip_csum();
        send_frame();
        build_frame(5, 5, 6, 0, FILL_RANDOM);
        frame_buf[POS_PROTOCOL] = PROTO_UDP;
        fix_ip_csum();
        send_frame();
        // ihl below the minimum header size
        build_frame(5, 5, 8, 0, FILL_RANDOM);
        frame_buf[POS_VER_IHL] = {tfv_pkg::IP_VERSION_4, 4'd4};
        fix_ip_csum();
        send_frame();
        // tcp data offset below the minimum header size
        build_frame(5, 5, 8, 0, FILL_RANDOM);
        st = tfv_pkg::ETH_BYTES + 20 + TCP_OFS_DOFF;
        frame_buf[st] = {4'd4, frame_buf[st][3:0]};
        fix_tcp_csum();
        send_frame();
        wait_drained();
    endtask

    task automatic test_checksum_faults();
        int last;
        build_frame(5, 5, 6, 0, FILL_RANDOM);
        frame_buf[POS_IP_CSUM + 1] = frame_buf[POS_IP_CSUM + 1] ^ 8'h01;
        send_frame();
        build_frame(5, 5, 6, 0, FILL_RANDOM);
        frame_buf[tfv_pkg::ETH_BYTES + 20 + TCP_OFS_CSUM] =
            frame_buf[tfv_pkg::ETH_BYTES + 20 + TCP_OFS_CSUM] ^ 8'h80;
        send_frame();
        // odd segment, the padded byte itself is wrong
        build_frame(5, 5, 3, 0, FILL_RANDOM);
        last = frame_buf.size() - 1;
        frame_buf[last] = frame_buf[last] ^ 8'h10;
        send_frame();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int         frames, start_bytes, kind, idx, len, k;
        logic [7:0] v;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        frames      = 0;
        start_bytes = bytes_sent;
        while (frames < 14 || bytes_sent - start_bytes < 270)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                build_random_frame();
                if (kind >= 60)
                begin
                    case ($urandom_range(2))
                        0:
                        begin
                            idx = $urandom_range(frame_buf.size() - 1);
                            k = $urandom_range(7);
                            v = frame_buf[idx];
                            v[k] = ~v[k];
                            frame_buf[idx] = v;
                        end
                        1:
                        begin
                            len = $urandom_range(1, frame_buf.size() - 1);
                            while (frame_buf.size() > len)
                                void'(frame_buf.pop_back());
                        end
                        default:
                            frame_buf[$urandom_range(POS_ETHERTYPE, 53)] = $urandom_range(255);
                    endcase
                end
            end
            else
            begin
                // raw noise of assorted length
                len = ($urandom_range(9) == 0) ? $urandom_range(31, 70) : $urandom_range(1, 30);
                frame_buf.delete();
                repeat (len) frame_buf.push_back($urandom_range(255));
            end
            send_frame();
            frames++;
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_len   = 600;
        hold_req_id++;
        // queue fills behind the held output and the input has to stall
        repeat (14)
        begin
            build_frame(5, 5, $urandom_range(8), 0, FILL_RANDOM);
            send_frame();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_frames();
        test_length_limits();
        test_header_faults();
        test_checksum_faults();
        test_random_traffic(0, 0);
        test_random_traffic(58, 0);
        test_random_traffic(0, 58);
        test_random_traffic(20, 20);
        test_output_backpressure();

        repeat (8) @(posedge clk);

        $display("run covered %0d frames in %0d byte beats, %0d result beats, %0d frames accepted",
                 frames_sent, bytes_sent, results_seen, accepted_frames);
        $display("directed header, length and checksum cases, random traffic under four idle mixes, long output hold-off");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
